FILE: rtl/sm4c_pkg.sv
// ----------------------------------------------------------------------------
// sm4c_pkg
// shared constants, the sbox table and a helper function for the sm4 cfb stream core
// ----------------------------------------------------------------------------
package sm4c_pkg;

   localparam int BLOCK_BYTES = 16;
   localparam int ROUND_COUNT = 32;
   localparam int RK_AW       = $clog2(ROUND_COUNT);

   // register indexes on the configuration port
   localparam logic [2:0] REG_KEY_HIGH = 3'd0;
   localparam logic [2:0] REG_KEY_LOW  = 3'd1;
   localparam logic [2:0] REG_IV_HIGH  = 3'd2;
   localparam logic [2:0] REG_IV_LOW   = 3'd3;
   localparam logic [2:0] REG_SEGMENT  = 3'd4;
   localparam logic [2:0] REG_DECRYPT  = 3'd5;

   localparam logic [127:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // key schedule constant for one round: byte j is ((4r+j)*7) mod 256
   function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] r);
      logic [9:0] prod;
      logic [31:0] w;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         prod = ({3'b000, r, 2'b00} + 10'(j)) * 10'd7;
         w = {w[23:0], prod[7:0]};
      end
      return w;
   endfunction

endpackage

FILE: rtl/sm4c_ram.sv
// ----------------------------------------------------------------------------
// sm4c_ram
// generic single-port-write ram with one registered read port
// ----------------------------------------------------------------------------
module sm4c_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sm4c_round.sv
// ----------------------------------------------------------------------------
// sm4c_round
// one sm4 round, shared by the key schedule and the block encryption
// ----------------------------------------------------------------------------
module sm4c_round (
   input  logic [127:0] work,
   input  logic [31:0]  rkey,
   input  logic         key_mode,
   output logic [31:0]  next_word
);
   import sm4c_pkg::*;

   logic [31:0] mix;
   logic [31:0] subst;
   logic [31:0] lin;

   // non-linear layer
   always_comb begin
      mix = work[95:64] ^ work[63:32] ^ work[31:0] ^ rkey;
      for (int i = 0; i < 4; i++) begin
         subst[8*i +: 8] = SBOX[mix[8*i +: 8]];
      end
   end

   // linear layer: key schedule or data path variant
   always_comb begin
      if (key_mode) begin
         lin = subst ^ {subst[18:0], subst[31:19]} ^ {subst[8:0], subst[31:9]};
      end else begin
         lin = subst ^ {subst[29:0], subst[31:30]} ^ {subst[21:0], subst[31:22]}
             ^ {subst[13:0], subst[31:14]} ^ {subst[7:0], subst[31:8]};
      end
      next_word = work[127:96] ^ lin;
   end

endmodule

FILE: rtl/sm4_cfb_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// sm4_cfb_stream_cipher_core
// sm4 cipher feedback stream core, one byte per item, segment of 1..16 bytes
// ----------------------------------------------------------------------------
// usage:
//   req channel: tdata = data byte, tuser = first (restart message), tlast =
//   last byte of message. rsp channel: tdata = byte xor keystream, tlast =
//   copy of last. key, iv, segment size and mode are written over the csr
//   port (64-bit registers at byte address 8*index) between messages.
// timing:
//   one round of a single shared sm4 round unit runs per cycle.
//   an item with first set runs the key schedule, then an sm4 block pass;
//   an item opening a segment takes the block pass only; other items go
//   straight to the output step. req_tready is low from acceptance until
//   the result is loaded into the output register, so a new byte is taken
//   only after the last one is through.
// reset: segment size 16, encrypt, key/iv zero, feedback register zero.
// stall: a result waits in the output register; the block finishes the next
//   item up to its result and holds there until the slot is free.
// ----------------------------------------------------------------------------
module sm4_cfb_stream_cipher_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] first
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import sm4c_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_KEYX = 3'd1;
   localparam logic [2:0] ST_PREF = 3'd2;
   localparam logic [2:0] ST_ENC  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]   state_ff, state_in;
   logic [63:0]  key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;
   logic [4:0]   seg_cfg_ff;
   logic         decrypt_ff;
   logic [127:0] work_ff, work_in;
   logic [127:0] fb_ff, fb_in;
   logic [127:0] ks_ff, ks_in;
   logic [127:0] fill_ff, fill_in;
   logic [3:0]   pos_ff, pos_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic [7:0]   data_ff;
   logic         last_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_data_ff, rsp_data_in;
   logic         rsp_last_ff, rsp_last_in;
   logic         csr_wr;
   logic [2:0]   csr_idx;
   logic         req_acc;
   logic [31:0]  nx;
   logic [31:0]  rk_rd;
   logic [31:0]  round_key;
   logic         key_mode;
   logic         rk_we;
   logic [4:0]   rk_raddr;
   logic [4:0]   seg;
   logic [7:0]   o_byte;
   logic [4:0]   len;
   logic         close_seg;
   logic [4:0]   src;
   logic [4:0]   tail_i;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[5:3];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         iv_high_ff  <= '0;
         iv_low_ff   <= '0;
         seg_cfg_ff  <= 5'd16;
         decrypt_ff  <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_KEY_HIGH: key_high_ff <= csr_pwdata;
            REG_KEY_LOW:  key_low_ff  <= csr_pwdata;
            REG_IV_HIGH:  iv_high_ff  <= csr_pwdata;
            REG_IV_LOW:   iv_low_ff   <= csr_pwdata;
            REG_SEGMENT:  seg_cfg_ff  <= csr_pwdata[4:0];
            REG_DECRYPT:  decrypt_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_KEY_HIGH: csr_prdata = key_high_ff;
         REG_KEY_LOW:  csr_prdata = key_low_ff;
         REG_IV_HIGH:  csr_prdata = iv_high_ff;
         REG_IV_LOW:   csr_prdata = iv_low_ff;
         REG_SEGMENT:  csr_prdata = {59'd0, seg_cfg_ff};
         REG_DECRYPT:  csr_prdata = {63'd0, decrypt_ff};
         default:      csr_prdata = '0;
      endcase
   end

   // round key store and shared round unit
   assign key_mode  = (state_ff == ST_KEYX);
   assign round_key = key_mode ? ck_word(cnt_ff) : rk_rd;
   assign rk_we     = key_mode;
   assign rk_raddr  = (state_ff == ST_ENC) ? cnt_ff + 5'd1 : 5'd0;

   sm4c_ram #(.WIDTH(32), .DEPTH(ROUND_COUNT)) u_rk_ram (
      .clock   (clock),
      .wr_en   (rk_we),
      .wr_addr (cnt_ff),
      .wr_data (nx),
      .rd_addr (rk_raddr),
      .rd_data (rk_rd)
   );

   sm4c_round u_round (
      .work      (work_ff),
      .rkey      (round_key),
      .key_mode  (key_mode),
      .next_word (nx)
   );

   // segment size clamp and output byte
   always_comb begin
      if (seg_cfg_ff == 5'd0) begin
         seg = 5'd1;
      end else if (seg_cfg_ff > 5'd16) begin
         seg = 5'd16;
      end else begin
         seg = seg_cfg_ff;
      end
      o_byte    = data_ff ^ ks_ff[8*(15 - pos_ff) +: 8];
      close_seg = ({1'b0, pos_ff} + 5'd1 >= seg) | last_ff;
      len       = ({1'b0, pos_ff} + 5'd1 < seg) ? {1'b0, pos_ff} + 5'd1 : seg;
   end

   // feedback fill and shift of the register
   always_comb begin
      src     = '0;
      tail_i  = '0;
      fill_in = fill_ff;
      fill_in[8*pos_ff +: 8] = decrypt_ff ? data_ff : o_byte;
      fb_in = fb_ff;
      for (int j = 0; j < BLOCK_BYTES; j++) begin
         if (5'(j) < 5'd16 - seg) begin
            src = 5'(j) + seg;
            fb_in[8*(15 - j) +: 8] = fb_ff[8*(15 - src[3:0]) +: 8];
         end else begin
            tail_i = 5'(j) + seg - 5'd16;
            if (tail_i < len) begin
               fb_in[8*(15 - j) +: 8] = fill_in[8*tail_i[3:0] +: 8];
            end
         end
      end
   end

   // sequencer
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;

   always_comb begin
      state_in     = state_ff;
      work_in      = work_ff;
      cnt_in       = cnt_ff;
      ks_in        = ks_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser) begin
                  work_in  = {key_high_ff, key_low_ff} ^ FK;
                  cnt_in   = '0;
                  pos_in   = '0;
                  state_in = ST_KEYX;
               end else if (pos_ff == 4'd0) begin
                  state_in = ST_PREF;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_KEYX: begin
            work_in = {work_ff[95:0], nx};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(ROUND_COUNT - 1)) begin
               state_in = ST_PREF;
            end
         end
         ST_PREF: begin
            work_in  = fb_ff;
            cnt_in   = '0;
            state_in = ST_ENC;
         end
         ST_ENC: begin
            work_in = {work_ff[95:0], nx};
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(ROUND_COUNT - 1)) begin
               ks_in    = {nx, work_ff[31:0], work_ff[63:32], work_ff[95:64]};
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = o_byte;
               rsp_last_in  = last_ff;
               pos_in       = close_seg ? 4'd0 : pos_ff + 4'd1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         fb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (req_acc && req_tuser) begin
            fb_ff <= {iv_high_ff, iv_low_ff};
         end else if (state_ff == ST_OUT && state_in == ST_IDLE && close_seg) begin
            fb_ff <= fb_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      ks_ff       <= ks_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (req_acc) begin
         data_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      if (state_ff == ST_OUT && state_in == ST_IDLE) begin
         fill_ff <= fill_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sm4 cfb stream core: a directed table of items,
// a short final segment, then random messages, every result checked against an sm4 cfb predictor
// ----------------------------------------------------------------------------
module tb_top;
   import sm4c_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first;
      logic       last;
   } msg_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } cipher_out_type;

   // directed row: item plus optional typed-in result
   typedef struct packed {
      msg_item_type item;
      logic         fixed;
      logic [7:0]   fixed_byte;
   } dir_row_type;

   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int NUM_RANDOM   = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   sm4_cfb_stream_cipher_core i_dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [63:0]  cfg_key_hi, cfg_key_lo, cfg_iv_hi, cfg_iv_lo;
   logic [4:0]   cfg_seg;
   logic         cfg_dec;
   logic [127:0] fb_reg;
   logic [31:0]  rk [ROUND_COUNT];
   logic [7:0]   ks [BLOCK_BYTES];
   logic [7:0]   seg_fill [BLOCK_BYTES];
   int unsigned  byte_pos;

   cipher_out_type expected_q [$];
   int           fail_count = 0;
   int           results_seen = 0;
   int           items_sent = 0;
   longint       cycle_count = 0;
   bit           long_hold = 1'b0;
   bit           hold_done = 1'b0;

   function automatic logic [31:0] sbox_word(logic [31:0] x);
      return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
   endfunction

   function automatic logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic schedule_keys();
      logic [31:0] k [4];
      logic [31:0] ck, b, nk;
      logic [7:0]  cb;
      k[0] = cfg_key_hi[63:32] ^ 32'ha3b1bac6;
      k[1] = cfg_key_hi[31:0]  ^ 32'h56aa3350;
      k[2] = cfg_key_lo[63:32] ^ 32'h677d9197;
      k[3] = cfg_key_lo[31:0]  ^ 32'hb27022dc;
      for (int i = 0; i < ROUND_COUNT; i++) begin
         ck = '0;
         for (int j = 0; j < 4; j++) begin
            cb = 8'((4 * i + j) * 7);
            ck = {ck[23:0], cb};
         end
         b  = sbox_word(k[1] ^ k[2] ^ k[3] ^ ck);
         nk = k[0] ^ b ^ rol(b, 13) ^ rol(b, 23);
         rk[i] = nk;
         k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
      end
   endtask

   task automatic encrypt_feedback();
      logic [31:0] x [4];
      logic [31:0] b, nx;
      logic [127:0] outw;
      x[0] = fb_reg[127:96]; x[1] = fb_reg[95:64];
      x[2] = fb_reg[63:32];  x[3] = fb_reg[31:0];
      for (int i = 0; i < ROUND_COUNT; i++) begin
         b  = sbox_word(x[1] ^ x[2] ^ x[3] ^ rk[i]);
         nx = x[0] ^ b ^ rol(b, 2) ^ rol(b, 10) ^ rol(b, 18) ^ rol(b, 24);
         x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
      end
      outw = {x[3], x[2], x[1], x[0]};
      for (int i = 0; i < BLOCK_BYTES; i++) ks[i] = outw[127 - 8 * i -: 8];
   endtask

   // cfb step: one byte in, one byte out, feedback on segment close
   task automatic cfb_predict(input msg_item_type it, output cipher_out_type res);
      int unsigned seg, pos, len;
      logic [7:0]  bb [BLOCK_BYTES];
      logic [7:0]  o;
      seg = cfg_seg;
      if (seg < 1) seg = 1;
      if (seg > BLOCK_BYTES) seg = BLOCK_BYTES;
      if (it.first) begin
         schedule_keys();
         fb_reg = {cfg_iv_hi, cfg_iv_lo};
         byte_pos = 0;
      end
      pos = byte_pos % BLOCK_BYTES;
      if (pos == 0) encrypt_feedback();
      o = it.data_byte ^ ks[pos];
      seg_fill[pos] = cfg_dec ? it.data_byte : o;
      pos++;
      if (pos >= seg || it.last) begin
         len = (pos < seg) ? pos : seg;
         for (int i = 0; i < BLOCK_BYTES; i++) bb[i] = fb_reg[127 - 8 * i -: 8];
         for (int i = 0; i < BLOCK_BYTES - seg; i++) bb[i] = bb[i + seg];
         for (int i = 0; i < len; i++) bb[BLOCK_BYTES - seg + i] = seg_fill[i];
         for (int i = 0; i < BLOCK_BYTES; i++) fb_reg[127 - 8 * i -: 8] = bb[i];
         pos = 0;
      end
      byte_pos = pos;
      res.out_byte = o;
      res.out_last = it.last;
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch at cycle %0d: %s got %02h expected %02h",
               cycle_count, what, got, want);
      fail_count++;
   endtask

   // cycle counter and timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      cipher_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, 8'h00);
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata !== want.out_byte)
               report_mismatch("out_byte", rsp_tdata, want.out_byte);
            if (rsp_tlast !== want.out_last)
               report_mismatch("out_last", {7'd0, rsp_tlast}, {7'd0, want.out_last});
         end
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      int wait_n;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if (wait_n > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         rsp_tready <= 1'b0;
      end
   end

   // setup and access cycle; the bus is released by the caller
   task automatic csr_write(input logic [2:0] idx, input logic [63:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_KEY_HIGH: cfg_key_hi = val;
         REG_KEY_LOW:  cfg_key_lo = val;
         REG_IV_HIGH:  cfg_iv_hi  = val;
         REG_IV_LOW:   cfg_iv_lo  = val;
         REG_SEGMENT:  cfg_seg    = val[4:0];
         REG_DECRYPT:  cfg_dec    = val[0];
         default: ;
      endcase
   endtask

   // wait for the block to drain before touching registers
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic send_item(input msg_item_type it, input bit idle_ok);
      cipher_out_type res;
      int gap;
      gap = idle_ok ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17)) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      cfb_predict(it, res);
      req_tvalid <= 1'b1;
      req_tdata  <= it.data_byte;
      req_tuser  <= it.first;
      req_tlast  <= it.last;
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(res);
      items_sent++;
   endtask

   task automatic set_config(input logic [63:0] kh, kl, ih, il,
                             input logic [4:0] seg, input logic dec);
      csr_write(REG_KEY_HIGH, kh);
      csr_write(REG_KEY_LOW,  kl);
      csr_write(REG_IV_HIGH,  ih);
      csr_write(REG_IV_LOW,   il);
      csr_write(REG_SEGMENT,  {59'd0, seg});
      csr_write(REG_DECRYPT,  {63'd0, dec});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   dir_row_type directed [] = '{
      '{'{8'h00, 1'b1, 1'b0}, 1'b0, 8'h00},
      '{'{8'hff, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{8'h55, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{8'haa, 1'b0, 1'b1}, 1'b0, 8'h00},
      '{'{8'h01, 1'b1, 1'b1}, 1'b0, 8'h00},
      '{'{8'h80, 1'b1, 1'b0}, 1'b0, 8'h00},
      '{'{8'h7f, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{8'hfe, 1'b0, 1'b1}, 1'b0, 8'h00}
   };

   initial begin
      msg_item_type   it;
      cipher_out_type res;
      int             msg_len, seg_sel;
      logic [4:0]     seg_val;
      cfg_key_hi = '0; cfg_key_lo = '0; cfg_iv_hi = '0; cfg_iv_lo = '0;
      cfg_seg = 5'd16; cfg_dec = 1'b0;
      fb_reg = '0; byte_pos = 0;
      for (int i = 0; i < BLOCK_BYTES; i++) begin ks[i] = '0; seg_fill[i] = '0; end
      for (int i = 0; i < ROUND_COUNT; i++) rk[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: segment size 16 in encrypt mode, then segment sizes 1 and 0
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: set_config(64'h0123456789abcdef, 64'hfedcba9876543210,
                          64'h0, 64'h0, 5'd16, 1'b0);
            1: set_config('1, '1, '1, '1, 5'd1, 1'b1);
            default: set_config(64'h0, 64'h0, 64'hdeadbeef00c0ffee,
                                64'h1, 5'd0, 1'b0);
         endcase
         foreach (directed[r]) begin
            send_item(directed[r].item, 1'b1);
            if (directed[r].fixed) begin
               res = expected_q[expected_q.size() - 1];
               if (res.out_byte !== directed[r].fixed_byte)
                  report_mismatch("table", res.out_byte, directed[r].fixed_byte);
            end
         end
         drain();
      end

      // segment size above 16 acts as 16; short final segment
      set_config(64'h1111, 64'h2222, 64'h3333, 64'h4444, 5'd31, 1'b1);
      for (int i = 0; i < 5; i++) begin
         it = '{8'($urandom), i == 0, i == 4};
         send_item(it, 1'b1);
      end
      drain();

      // random messages over several settings, one long output hold-off
      while (items_sent < NUM_RANDOM + 30) begin
         seg_sel = $urandom_range(0, 5);
         seg_val = (seg_sel == 0) ? 5'd1 : (seg_sel == 1) ? 5'd16 :
                   (seg_sel == 2) ? 5'($urandom_range(17, 31)) :
                   5'($urandom_range(2, 15));
         set_config({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom},
                    seg_val, 1'($urandom));
         if (items_sent > 150 && !hold_done) begin
            long_hold = 1'b1;
            hold_done = 1'b1;
         end
         for (int m = 0; m < 3; m++) begin
            msg_len = $urandom_range(1, 40);
            for (int i = 0; i < msg_len; i++) begin
               it.data_byte = 8'($urandom);
               it.first = (i == 0) || ($urandom_range(0, 40) == 0);
               it.last  = (i == msg_len - 1) || ($urandom_range(0, 40) == 0);
               send_item(it, $urandom_range(0, 4) != 0);
            end
         end
         drain();
      end

      drain();
      $display("covered %0d items, %0d results checked, segment sizes 0..31,",
               items_sent, results_seen);
      $display("both modes, short final segments and a long output stall");
      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d failures, %0d results outstanding", fail_count,
                  expected_q.size());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/sm4c_pkg.sv
rtl/sm4c_ram.sv
rtl/sm4c_round.sv
rtl/sm4_cfb_stream_cipher_core.sv
tb/sv/tb_top.sv
